// ===== hdl/kef_pkg.sv =====
// shared constants and word types for the kruskal edge filter
package kef_pkg;

  localparam int NODE_W        = 10;
  localparam int NC_W          = 11;
  localparam int CNT_W         = NC_W;
  localparam int RANK_W        = 4;
  localparam int EPOCH_W       = 8;
  localparam int MAX_NODES_DEF = 1024;

  localparam logic [RANK_W-1:0]  RANK_MAX       = 4'd15;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST     = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST    = 8'h01;
  localparam logic [NC_W-1:0]    NODE_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic              new_graph;
    logic [NODE_W-1:0] end_u;
    logic [NODE_W-1:0] end_v;
  } kef_item_t;

  typedef struct packed {
    logic              accepted;
    logic [NODE_W-1:0] out_u;
    logic [NODE_W-1:0] out_v;
    logic [NODE_W-1:0] accepted_total;
    logic              tree_complete;
  } kef_res_t;

endpackage

// ===== hdl/kef_in_if.sv =====
// edge input channel
interface kef_in_if;
  import kef_pkg::*;

  logic              valid;
  logic              ready;
  logic              new_graph;
  logic [NODE_W-1:0] end_u;
  logic [NODE_W-1:0] end_v;

  modport source (output valid, output new_graph, output end_u, output end_v, input ready);
  modport sink (input valid, input new_graph, input end_u, input end_v, output ready);
endinterface

// ===== hdl/kef_out_if.sv =====
// result output channel
interface kef_out_if;
  import kef_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [NODE_W-1:0] out_u;
  logic [NODE_W-1:0] out_v;
  logic [NODE_W-1:0] accepted_total;
  logic              tree_complete;

  modport source (output valid, output accepted, output out_u, output out_v,
                  output accepted_total, output tree_complete, input ready);
  modport sink (input valid, input accepted, input out_u, input out_v,
                input accepted_total, input tree_complete, output ready);
endinterface

// ===== hdl/kruskal_edge_filter_top.sv =====
// kruskal edge filter: union-find acceptance stage of a spanning tree build
//
// Each input word is one graph edge (two node indices, already in the wanted order); each
// produces one result word that says whether the edge joined two separate sets, echoes the
// endpoints, and gives the accepted-edge count and a tree-complete flag. Setting new_graph on
// an edge starts a fresh graph before that edge is judged. node_count is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the block
// does not enforce. 0 counts as 1 and values above MAX_NODES as MAX_NODES. The set
// structure sits in one synchronous single-read memory of MAX_NODES words, each holding
// parent, rank and an 8-bit graph tag; a word whose tag is not the current one reads as a
// singleton, so a new graph costs nothing in the common case. Items are handled one at a
// time, paced by the memory's one read per cycle: an edge rejected up front (tree complete
// or endpoint out of range) skips the root walks; any other edge walks both ends to their
// roots, each path-halving step writing the store, plus a rank write when two equal-rank
// roots are joined. After reset, and once every 255 new graphs when the tag wraps, a
// clearing pass over all MAX_NODES words runs with in_ready low. The result sits in an
// output register, so the next edge is taken while an earlier result waits for out_ready.
module kruskal_edge_filter_top #(
  parameter int MAX_NODES = kef_pkg::MAX_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  kef_in_if.sink                   in_ch,
  kef_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [kef_pkg::NC_W-1:0] cfg_wdata
);
  import kef_pkg::*;

  localparam int AW        = $clog2(MAX_NODES);
  localparam int WW        = EPOCH_W + RANK_W + AW;
  localparam int NC_CLAMP  = (MAX_NODES > 2047) ? 2047 : MAX_NODES;

  // node count register and its clamped value
  logic [NC_W-1:0] node_count_r;
  logic [NC_W-1:0] node_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    node_lim = (node_count_r == '0) ? NC_W'(1) : node_count_r;
    if (32'(node_lim) > 32'(MAX_NODES)) begin
      node_lim = NC_W'(NC_CLAMP);
    end
  end

  // input word into the sequencer
  kef_item_t in_item;
  logic      in_ready;

  assign in_item.new_graph = in_ch.new_graph;
  assign in_item.end_u     = in_ch.end_u;
  assign in_item.end_v     = in_ch.end_v;
  assign in_ch.ready       = in_ready;

  // sequencer <-> store
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  // sequencer result and output register
  kef_res_t res;
  logic     res_valid, res_taken;
  logic     out_valid_r;
  kef_res_t out_res_r;

  kef_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .node_lim  (node_lim),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  kef_store #(.DEPTH(MAX_NODES), .WW(WW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register loads when empty or being drained this cycle
  assign res_taken = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_res_r.accepted;
  assign out_ch.out_u          = out_res_r.out_u;
  assign out_ch.out_v          = out_res_r.out_v;
  assign out_ch.accepted_total = out_res_r.accepted_total;
  assign out_ch.tree_complete  = out_res_r.tree_complete;

  // one edge in flight: accepting a word closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // the store is only written while an edge or the clearing pass is in work
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_ready)
    else $error("store written while idle");

  // an accepted edge always leaves a nonzero count
  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted) |-> (out_ch.accepted_total != '0))
    else $error("accepted edge with zero total");

  // a word is only loaded into the output register when it is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_taken)
    else $error("held result overwritten");
endmodule

// ===== hdl/kef_store.sv =====
// union-find store: one write port, one registered read port with write forwarding
module kef_store #(
  parameter int DEPTH = kef_pkg::MAX_NODES_DEF,
  parameter int WW    = 22,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [WW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [WW-1:0] rdata
);
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-address write wins over the stored word
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/kef_ctrl.sv =====
// sequencer: root walks with path halving, union by rank, epoch tags and clearing pass
module kef_ctrl #(
  parameter int MAX_NODES = kef_pkg::MAX_NODES_DEF,
  localparam int AW = $clog2(MAX_NODES),
  localparam int WW = kef_pkg::EPOCH_W + kef_pkg::RANK_W + AW
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  kef_pkg::kef_item_t      in_item,
  input  logic [kef_pkg::NC_W-1:0] node_lim,
  output logic                    res_valid,
  input  logic                    res_taken,
  output kef_pkg::kef_res_t       res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [WW-1:0]           mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [WW-1:0]           mem_rdata
);
  import kef_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_FX    = 4'd4;
  localparam logic [3:0] S_FP    = 4'd5;
  localparam logic [3:0] S_JOIN1 = 4'd6;
  localparam logic [3:0] S_JOIN2 = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  logic [3:0]         state_r, state_nxt;
  kef_item_t          item_r, item_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]      x_r, x_nxt;
  logic [AW-1:0]      p_r, p_nxt;
  logic [AW-1:0]      ru_r, ru_nxt;
  logic [AW-1:0]      rv_r, rv_nxt;
  logic [RANK_W-1:0]  xrank_r, xrank_nxt;
  logic [RANK_W-1:0]  rku_r, rku_nxt;
  logic [RANK_W-1:0]  rkv_r, rkv_nxt;
  logic               which_r, which_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ok_r, ok_nxt;

  logic [EPOCH_W-1:0] rd_tag;
  logic [RANK_W-1:0]  rd_rank_raw, rd_rank;
  logic [AW-1:0]      rd_par_raw, rd_par, rd_addr;
  logic               rd_live;
  logic [NC_W-1:0]    lim_m1;
  logic               go;
  logic [AW-1:0]      u_idx, v_idx;

  assign {rd_tag, rd_rank_raw, rd_par_raw} = mem_rdata;
  assign rd_addr = (state_r == S_FP) ? p_r : x_r;
  // an entry from an older epoch reads as a singleton
  assign rd_live = (rd_tag == epoch_r);
  assign rd_par  = rd_live ? rd_par_raw : rd_addr;
  assign rd_rank = rd_live ? rd_rank_raw : '0;

  assign u_idx  = AW'(item_r.end_u);
  assign v_idx  = AW'(item_r.end_v);
  assign lim_m1 = node_lim - 1'b1;
  assign go     = (count_r < lim_m1) && ({1'b0, item_r.end_u} < node_lim)
                  && ({1'b0, item_r.end_v} < node_lim);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.accepted       = ok_r;
    res.out_u          = item_r.end_u;
    res.out_v          = item_r.end_v;
    res.accepted_total = count_r[NODE_W-1:0];
    res.tree_complete  = (count_r >= lim_m1);
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    pend_nxt    = pend_r;
    clr_idx_nxt = clr_idx_r;
    x_nxt       = x_r;
    p_nxt       = p_r;
    ru_nxt      = ru_r;
    rv_nxt      = rv_r;
    xrank_nxt   = xrank_r;
    rku_nxt     = rku_r;
    rkv_nxt     = rkv_r;
    which_nxt   = which_r;
    epoch_nxt   = epoch_r;
    count_nxt   = count_r;
    ok_nxt      = ok_r;
    mem_we      = 1'b0;
    mem_waddr   = x_r;
    mem_wdata   = '0;
    mem_raddr   = x_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_START;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == LAST_IDX) begin
          clr_idx_nxt = '0;
          epoch_nxt   = EPOCH_FIRST;
          pend_nxt    = 1'b0;
          state_nxt   = pend_r ? S_CHECK : S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_START: begin
        state_nxt = S_CHECK;
        if (item_r.new_graph) begin
          count_nxt = '0;
          if (epoch_r == EPOCH_LAST) begin
            // tags about to wrap: sweep the store first
            pend_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (go) begin
          x_nxt     = u_idx;
          mem_raddr = u_idx;
          which_nxt = 1'b0;
          state_nxt = S_FX;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_FX: begin
        if (rd_par == x_r) begin
          if (!which_r) begin
            ru_nxt    = x_r;
            rku_nxt   = rd_rank;
            which_nxt = 1'b1;
            x_nxt     = v_idx;
            mem_raddr = v_idx;
          end else begin
            rv_nxt    = x_r;
            rkv_nxt   = rd_rank;
            state_nxt = S_JOIN1;
          end
        end else begin
          p_nxt     = rd_par;
          xrank_nxt = rd_rank;
          mem_raddr = rd_par;
          state_nxt = S_FP;
        end
      end
      S_FP: begin
        // path halving: x skips to its grandparent
        mem_we    = 1'b1;
        mem_waddr = x_r;
        mem_wdata = {epoch_r, xrank_r, rd_par};
        x_nxt     = rd_par;
        mem_raddr = rd_par;
        state_nxt = S_FX;
      end
      S_JOIN1: begin
        if (ru_r == rv_r) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else begin
          ok_nxt    = 1'b1;
          count_nxt = count_r + 1'b1;
          mem_we    = 1'b1;
          if (rku_r < rkv_r) begin
            mem_waddr = ru_r;
            mem_wdata = {epoch_r, rku_r, rv_r};
            state_nxt = S_DONE;
          end else begin
            mem_waddr = rv_r;
            mem_wdata = {epoch_r, rkv_r, ru_r};
            state_nxt = (rku_r == rkv_r) ? S_JOIN2 : S_DONE;
          end
        end
      end
      S_JOIN2: begin
        mem_we    = 1'b1;
        mem_waddr = ru_r;
        mem_wdata = {epoch_r, (rku_r == RANK_MAX) ? rku_r : rku_r + 1'b1, ru_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      pend_r    <= 1'b0;
      clr_idx_r <= '0;
      epoch_r   <= EPOCH_FIRST;
      count_r   <= '0;
      which_r   <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      clr_idx_r <= clr_idx_nxt;
      epoch_r   <= epoch_nxt;
      count_r   <= count_nxt;
      which_r   <= which_nxt;
      ok_r      <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    x_r     <= x_nxt;
    p_r     <= p_nxt;
    ru_r    <= ru_nxt;
    rv_r    <= rv_nxt;
    xrank_r <= xrank_nxt;
    rku_r   <= rku_nxt;
    rkv_r   <= rkv_nxt;
  end
endmodule

// ===== tb/sv/kruskal_edge_filter_top_test.sv =====
// self-checking testbench for the kruskal edge filter: directed table, then random graphs
module kruskal_edge_filter_top_test;
  import kef_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int MAX_N          = MAX_NODES_DEF;
  // reset clearing pass plus the long receiver hold, with plenty of margin
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_GAP      = 12;
  localparam int PHASE_WORDS    = 120;
  localparam int DIR_ROWS       = 23;
  localparam int MAX_PRINTS     = 20;

  // one row of the directed table; fixed rows carry the result typed in
  typedef struct {
    bit                set_nc;
    logic [NC_W-1:0]   nc;
    bit                ng;
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    bit                fixed;
    bit                acc;
    logic [NODE_W-1:0] tot;
    bit                done;
  } edge_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [NC_W-1:0] cfg_wdata;

  kef_in_if  in_ch ();
  kef_out_if out_ch ();

  kruskal_edge_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // own copy of the union-find forest and the node count register
  logic [NODE_W-1:0] forest_parent [MAX_N];
  logic [RANK_W-1:0] forest_rank [MAX_N];
  int                forest_edges;
  logic [NC_W-1:0]   nodes_cfg;

  // results still owed by the block, oldest first
  kef_res_t verdict_q [$];

  edge_row_t edge_plan [DIR_ROWS];

  int n_errors = 0;
  int n_checked = 0;
  int n_joined = 0;
  int n_sent = 0;
  int n_directed = 0;
  int n_cfg_writes = 0;
  int quiet_cycles = 0;

  // idling knobs, set by the stimulus, read by the driver and the receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  function automatic void clear_forest();
    for (int i = 0; i < MAX_N; i++) begin
      forest_parent[i] = NODE_W'(i);
      forest_rank[i]   = '0;
    end
    forest_edges = 0;
  endfunction

  // root walk with path halving, same shape as the block's store update
  function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] p;
    for (int guard = 0; guard < MAX_N; guard++) begin
      p = forest_parent[x];
      if (p == x) break;
      forest_parent[x] = forest_parent[p];
      x = forest_parent[x];
    end
    return x;
  endfunction

  // decides one edge and updates the forest: union by rank on acceptance
  function automatic kef_res_t judge_edge(kef_item_t it);
    int                n;
    logic [NODE_W-1:0] ru;
    logic [NODE_W-1:0] rv;
    kef_res_t          r;
    if (it.new_graph) clear_forest();
    // node count clamped into 1..MAX_N
    if (nodes_cfg == 0) n = 1;
    else if (nodes_cfg > MAX_N) n = MAX_N;
    else n = int'(nodes_cfg);
    r.accepted = 1'b0;
    if (forest_edges < n - 1 && int'(it.end_u) < n && int'(it.end_v) < n) begin
      ru = find_root(it.end_u);
      rv = find_root(it.end_v);
      if (ru != rv) begin
        if (forest_rank[ru] < forest_rank[rv]) begin
          forest_parent[ru] = rv;
        end else if (forest_rank[ru] > forest_rank[rv]) begin
          forest_parent[rv] = ru;
        end else begin
          forest_parent[rv] = ru;
          if (forest_rank[ru] != RANK_MAX) forest_rank[ru] = forest_rank[ru] + 1'b1;
        end
        forest_edges++;
        r.accepted = 1'b1;
      end
    end
    r.out_u          = it.end_u;
    r.out_v          = it.end_v;
    r.accepted_total = forest_edges[NODE_W-1:0];
    r.tree_complete  = (forest_edges >= n - 1);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0d, wanted %0d", n_checked, what, got, want);
  endtask

  // offers one word from a falling edge and returns at the rising edge that takes it
  task automatic send_edge(kef_item_t it, bit use_fixed, kef_res_t fixed_res);
    kef_res_t guess;
    kef_res_t owed;
    @(negedge clk);
    // random sender gaps, valid low meanwhile
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.new_graph <= it.new_graph;
    in_ch.end_u     <= it.end_u;
    in_ch.end_v     <= it.end_v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // predictor always runs so the forest stays in step with the block
    guess = judge_edge(it);
    owed  = use_fixed ? fixed_res : guess;
    verdict_q = {verdict_q, owed};
    n_sent++;
  endtask

  // drops valid on the falling edge after the last accepted word
  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // node count write, only once every owed result is back and the block has settled
  task automatic write_nodes(logic [NC_W-1:0] value);
    release_input();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    nodes_cfg = value;
    n_cfg_writes++;
  endtask

  // receiver: random stalls, plus one long hold in its own count
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: every taken result word against the oldest prediction
  always @(posedge clk) begin : check_results
    kef_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with nothing owed, out_u", int'(out_ch.out_u), -1);
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", int'(out_ch.accepted), int'(want.accepted));
        if (out_ch.out_u !== want.out_u)
          report_mismatch("out_u", int'(out_ch.out_u), int'(want.out_u));
        if (out_ch.out_v !== want.out_v)
          report_mismatch("out_v", int'(out_ch.out_v), int'(want.out_v));
        if (out_ch.accepted_total !== want.accepted_total)
          report_mismatch("accepted_total", int'(out_ch.accepted_total),
                          int'(want.accepted_total));
        if (out_ch.tree_complete !== want.tree_complete)
          report_mismatch("tree_complete", int'(out_ch.tree_complete),
                          int'(want.tree_complete));
        if (want.accepted) n_joined++;
      end
      n_checked++;
    end
  end

  // watchdog: too long with no word moving on either channel ends the run
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results owed",
               quiet_cycles, verdict_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int        row;
    int        ph;
    int        pick;
    int        nc;
    int        eff;
    int        n_words;
    int        e;
    int        phase_sent;
    bit        keep_store;
    kef_item_t it;
    kef_res_t  fixed_res;

    // every block input known from time zero
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.new_graph = 1'b0;
    in_ch.end_u     = '0;
    in_ch.end_v     = '0;
    out_ch.ready    = 1'b0;
    nodes_cfg       = NODE_COUNT_RST;
    clear_forest();

    // directed rows: set_nc, nc, new_graph, u, v, fixed, accepted, total, complete
    edge_plan = '{
      // after reset, full node range: extremes of the endpoints
      '{0, 11'd0,    0, 10'd0,    10'd1023, 1, 1, 10'd1, 0},
      '{0, 11'd0,    0, 10'd1023, 10'd0,    1, 0, 10'd1, 0},
      // self loop
      '{0, 11'd0,    0, 10'd5,    10'd5,    1, 0, 10'd1, 0},
      '{0, 11'd0,    0, 10'h2AA,  10'h155,  1, 1, 10'd2, 0},
      // new graph clears the earlier join
      '{0, 11'd0,    1, 10'd1023, 10'd0,    1, 1, 10'd1, 0},
      // node count zero acts as one: complete from the start
      '{1, 11'd0,    1, 10'd0,    10'd0,    1, 0, 10'd0, 1},
      '{0, 11'd0,    0, 10'd0,    10'd1,    1, 0, 10'd0, 1},
      // two nodes: one edge completes the tree
      '{1, 11'd2,    1, 10'd0,    10'd1,    1, 1, 10'd1, 1},
      '{0, 11'd0,    0, 10'd1,    10'd0,    1, 0, 10'd1, 1},
      // node count above the maximum is clamped
      '{1, 11'd2047, 1, 10'd1023, 10'd1022, 1, 1, 10'd1, 0},
      // endpoint out of range is rejected
      '{1, 11'd3,    1, 10'd3,    10'd0,    1, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd0,    10'd2,    1, 1, 10'd1, 0},
      '{0, 11'd0,    0, 10'd2,    10'd1,    1, 1, 10'd2, 1},
      // tree complete: later edges rejected
      '{0, 11'd0,    0, 10'd1,    10'd0,    1, 0, 10'd2, 1},
      // node count raised mid-graph keeps the store
      '{1, 11'd4,    0, 10'd3,    10'd0,    1, 1, 10'd3, 1},
      '{0, 11'd0,    0, 10'd3,    10'd3,    1, 0, 10'd3, 1},
      // a small forest left to the predictor
      '{1, 11'd8,    0, 10'd4,    10'd5,    0, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd6,    10'd7,    0, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd4,    10'd7,    0, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd5,    10'd6,    0, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd0,    10'd4,    0, 0, 10'd0, 0},
      // back to the full node range
      '{1, 11'd1024, 1, 10'd1023, 10'd1023, 1, 0, 10'd0, 0},
      '{0, 11'd0,    0, 10'd1023, 10'd0,    1, 1, 10'd1, 0}
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, no idling; the block's clearing pass holds in_ready low first
    for (row = 0; row < DIR_ROWS; row++) begin
      if (edge_plan[row].set_nc) write_nodes(edge_plan[row].nc);
      it.new_graph             = edge_plan[row].ng;
      it.end_u                 = edge_plan[row].u;
      it.end_v                 = edge_plan[row].v;
      fixed_res.accepted       = edge_plan[row].acc;
      fixed_res.out_u          = edge_plan[row].u;
      fixed_res.out_v          = edge_plan[row].v;
      fixed_res.accepted_total = edge_plan[row].tot;
      fixed_res.tree_complete  = edge_plan[row].done;
      send_edge(it, edge_plan[row].fixed, fixed_res);
    end
    n_directed = n_sent;
    fixed_res  = '0;

    // random graphs in four idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // no idling, but one long receiver hold so the block backs up
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_WORDS) begin
        // node count: mostly small graphs, some full size, some out of range
        pick = $urandom_range(99);
        if (pick < 60) nc = $urandom_range(16, 2);
        else if (pick < 72) nc = $urandom_range(40, 17);
        else if (pick < 80) nc = MAX_N;
        else if (pick < 86) nc = $urandom_range(1, 0);
        else if (pick < 92) nc = $urandom_range(2047, MAX_N + 1);
        else nc = $urandom_range(2047);
        if (nc == 0) eff = 1;
        else if (nc > MAX_N) eff = MAX_N;
        else eff = nc;
        if (eff <= 40) n_words = eff + eff / 2 + $urandom_range(6, 2);
        else n_words = $urandom_range(50, 20);
        // now and then carry the old forest over into the new node count
        keep_store = ($urandom_range(5) == 0);
        write_nodes(NC_W'(nc));
        for (e = 0; e < n_words; e++) begin
          it.new_graph = (e == 0 && !keep_store) || ($urandom_range(49) == 0);
          if (eff >= MAX_N || $urandom_range(9) == 0) begin
            // full-range endpoints: out of range noise on small graphs
            it.end_u = NODE_W'($urandom_range(1023));
            it.end_v = NODE_W'($urandom_range(1023));
          end else begin
            it.end_u = NODE_W'($urandom_range(eff - 1));
            it.end_v = NODE_W'($urandom_range(eff - 1));
          end
          if ($urandom_range(15) == 0) it.end_v = it.end_u;
          send_edge(it, 1'b0, fixed_res);
          phase_sent++;
        end
      end
    end

    // wait out every owed result, then let the block settle
    release_input();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);

    $display("covered %0d edge words (%0d directed) under %0d node count writes",
             n_sent, n_directed, n_cfg_writes);
    $display("%0d results checked, %0d joins, idling none/sender/receiver/both with a long hold",
             n_checked, n_joined);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kef_pkg.sv
hdl/kef_in_if.sv
hdl/kef_out_if.sv
hdl/kef_store.sv
hdl/kef_ctrl.sv
hdl/kruskal_edge_filter_top.sv
tb/sv/kruskal_edge_filter_top_test.sv
